// ===== rtl/core/osp_pkg.sv =====
`default_nettype none

package osp_pkg;

	localparam int COUNT_WIDTH_DEF = 32;
	localparam int PADDR_WIDTH     = 5;

	localparam logic [7:0] DARK_RUN_MIN_RST = 8'd2;
	localparam logic [7:0] RUN_LEN_MAX_RST  = 8'd8;
	localparam logic [7:0] RATE_MAX_RST     = 8'd8;
	localparam logic [7:0] ZERO_RUN_MAX_RST = 8'd4;
	localparam logic [7:0] INIT_RATE_RST    = 8'd2;

	typedef enum logic [2:0] {
		REG_DARK_RUN_MIN = 3'd0,
		REG_RUN_LEN_MAX  = 3'd1,
		REG_RATE_MAX     = 3'd2,
		REG_ZERO_RUN_MAX = 3'd3,
		REG_INIT_RATE    = 3'd4
	} reg_idx_t;

	typedef logic [3:0] phase_t;

	localparam phase_t PH_IDLE     = 4'd0;
	localparam phase_t PH_SECTOR_A = 4'd1;
	localparam phase_t PH_REPEAT_A = 4'd2;
	localparam phase_t PH_MIXED_A  = 4'd3;
	localparam phase_t PH_ZERO_A   = 4'd4;
	localparam phase_t PH_SECTOR_B = 4'd5;
	localparam phase_t PH_REPEAT_B = 4'd6;
	localparam phase_t PH_MIXED_B  = 4'd7;
	localparam phase_t PH_ZERO_B   = 4'd8;

	function automatic phase_t route(input phase_t cur, input logic [1:0] sym);
		phase_t row [4];
		case (cur) inside
			PH_SECTOR_A, PH_REPEAT_A, PH_MIXED_A, PH_ZERO_A: begin
				row = '{PH_ZERO_A, PH_REPEAT_A, PH_SECTOR_B, PH_MIXED_A};
			end
			PH_SECTOR_B, PH_REPEAT_B, PH_MIXED_B, PH_ZERO_B: begin
				row = '{PH_ZERO_B, PH_SECTOR_A, PH_REPEAT_B, PH_MIXED_B};
			end
			default: begin
				row = '{PH_IDLE, PH_SECTOR_A, PH_SECTOR_B, PH_IDLE};
			end
		endcase
		return row[sym];
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/optical_sector_pulse_counter.sv =====
// channel  dir  transfer when           payload
// symbol   in   symbol_valid & !stall   sensor_symbol
// result   out  result_valid & !stall   pulse_count, poll_rate, stopped, phase
// config   in   psel & penable & pwrite paddr, pwdata (prdata on read)
//
// one result per symbol; a symbol waits in the input register and its result is
// loaded into the result register once that is free, one symbol per cycle unless stalled
// result_stall holds a valid result register and, while it holds, the input register
// reset: all counters cleared, registers to their defaults, poll rate to 2
`default_nettype none

module optical_sector_pulse_counter #(
	parameter int COUNT_WIDTH = osp_pkg::COUNT_WIDTH_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            symbol_valid,
	output logic                                 symbol_stall,
	input  wire logic [1:0]                      sensor_symbol,
	output logic                                 result_valid,
	input  wire logic                            result_stall,
	output logic [31:0]                          pulse_count,
	output logic [7:0]                           poll_rate,
	output logic                                 stopped,
	output logic [3:0]                           phase,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [osp_pkg::PADDR_WIDTH-1:0] paddr,
	input  wire logic [31:0]                     pwdata,
	output logic [31:0]                          prdata,
	output logic                                 pready
);

	logic [7:0] dark_min_q, run_max_q, rate_max_q, zero_max_q, init_rate_q;

	osp_pkg::phase_t        phase_q;
	logic [7:0]             zero_run_q, dark_run_q, run_len_q, rate_q;
	logic [COUNT_WIDTH-1:0] count_q;
	logic                   stopped_q;

	logic       valid_s1;
	logic [1:0] sym_s1;

	osp_pkg::phase_t        phase_d;
	logic [7:0]             zero_run_d, dark_run_d, run_len_d, rate_d;
	logic [COUNT_WIDTH-1:0] count_d;
	logic                   stopped_d;

	logic             step;
	logic             cfg_wr;
	osp_pkg::reg_idx_t cfg_idx;
	logic             short_dark;

	assign pready       = 1'b1;
	assign cfg_wr       = psel & penable & pwrite;
	assign cfg_idx      = osp_pkg::reg_idx_t'(paddr[4:2]);
	assign step         = valid_s1 & (~result_valid | ~result_stall);
	assign symbol_stall = valid_s1 & ~step;
	assign short_dark   = (dark_run_q == 8'd0) || ((dark_run_q - 8'd1) < dark_min_q);

	always_comb begin
		unique case (cfg_idx)
			osp_pkg::REG_DARK_RUN_MIN: prdata = {24'd0, dark_min_q};
			osp_pkg::REG_RUN_LEN_MAX:  prdata = {24'd0, run_max_q};
			osp_pkg::REG_RATE_MAX:     prdata = {24'd0, rate_max_q};
			osp_pkg::REG_ZERO_RUN_MAX: prdata = {24'd0, zero_max_q};
			osp_pkg::REG_INIT_RATE:    prdata = {24'd0, init_rate_q};
			default:                   prdata = 32'd0;
		endcase
	end

	always_comb begin
		phase_d    = osp_pkg::route(phase_q, sym_s1);
		zero_run_d = zero_run_q;
		dark_run_d = dark_run_q;
		run_len_d  = run_len_q;
		rate_d     = rate_q;
		count_d    = count_q;
		stopped_d  = stopped_q;
		case (phase_d) inside
			osp_pkg::PH_IDLE: begin
				zero_run_d = 8'd0;
				dark_run_d = 8'd2;
				run_len_d  = 8'd1;
			end
			osp_pkg::PH_SECTOR_A, osp_pkg::PH_SECTOR_B: begin
				count_d = count_q + COUNT_WIDTH'(1);
				if (short_dark && rate_q != 8'd0) begin
					rate_d = rate_q - 8'd1;
				end
				zero_run_d = 8'd0;
				dark_run_d = 8'd2;
				run_len_d  = 8'd1;
			end
			osp_pkg::PH_REPEAT_A, osp_pkg::PH_REPEAT_B,
			osp_pkg::PH_MIXED_A, osp_pkg::PH_MIXED_B: begin
				if ((phase_d == osp_pkg::PH_REPEAT_A || phase_d == osp_pkg::PH_REPEAT_B)
				    && dark_run_q != 8'd0) begin
					dark_run_d = dark_run_q + 8'd1;
				end
				if (run_len_q < run_max_q) begin
					run_len_d = run_len_q + 8'd1;
				end else begin
					if (rate_q < rate_max_q) begin
						rate_d = rate_q + 8'd1;
					end
					run_len_d = 8'd1;
				end
			end
			default: begin
				if (zero_run_q < zero_max_q) begin
					zero_run_d = zero_run_q + 8'd1;
				end else begin
					stopped_d = 1'b1;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dark_min_q  <= osp_pkg::DARK_RUN_MIN_RST;
			run_max_q   <= osp_pkg::RUN_LEN_MAX_RST;
			rate_max_q  <= osp_pkg::RATE_MAX_RST;
			zero_max_q  <= osp_pkg::ZERO_RUN_MAX_RST;
			init_rate_q <= osp_pkg::INIT_RATE_RST;
			phase_q     <= osp_pkg::PH_IDLE;
			zero_run_q  <= 8'd0;
			dark_run_q  <= 8'd0;
			run_len_q   <= 8'd0;
			rate_q      <= osp_pkg::INIT_RATE_RST;
			count_q     <= '0;
			stopped_q   <= 1'b0;
		end else begin
			if (step && !stopped_q) begin
				phase_q    <= phase_d;
				zero_run_q <= zero_run_d;
				dark_run_q <= dark_run_d;
				run_len_q  <= run_len_d;
				rate_q     <= rate_d;
				count_q    <= count_d;
				stopped_q  <= stopped_d;
			end
			if (cfg_wr) begin
				unique case (cfg_idx)
					osp_pkg::REG_DARK_RUN_MIN: dark_min_q <= pwdata[7:0];
					osp_pkg::REG_RUN_LEN_MAX:  run_max_q  <= pwdata[7:0];
					osp_pkg::REG_RATE_MAX:     rate_max_q <= pwdata[7:0];
					osp_pkg::REG_ZERO_RUN_MAX: zero_max_q <= pwdata[7:0];
					osp_pkg::REG_INIT_RATE: begin
						init_rate_q <= pwdata[7:0];
						rate_q      <= pwdata[7:0];
					end
					default: ;
				endcase
			end
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!symbol_stall) begin
			valid_s1 <= symbol_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!symbol_stall && symbol_valid) begin
			sym_s1 <= sensor_symbol;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (step) begin
			result_valid <= 1'b1;
		end else if (!result_stall) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			if (stopped_q) begin
				pulse_count <= 32'(count_q);
				poll_rate   <= rate_q;
				stopped     <= stopped_q;
				phase       <= phase_q;
			end else begin
				pulse_count <= 32'(count_d);
				poll_rate   <= rate_d;
				stopped     <= stopped_d;
				phase       <= phase_d;
			end
		end
	end

`ifndef SYNTHESIS
	a_stopped_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		stopped_q |=> stopped_q)
		else $error("stopped flag cleared without reset");

	a_stopped_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		stopped_q |=> $stable(count_q) && $stable(phase_q))
		else $error("state moved while stopped");

	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q <= osp_pkg::PH_ZERO_B)
		else $error("phase out of route table range");

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		symbol_stall |-> valid_s1 && result_valid && result_stall)
		else $error("input stalled with room downstream");

	a_step_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		step |=> result_valid)
		else $error("symbol processed without a result transfer pending");
`endif

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
`default_nettype none

module tb_top;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 6;

	localparam logic [1:0] SYM_NONE   = 2'd0;
	localparam logic [1:0] SYM_FIRST  = 2'd1;
	localparam logic [1:0] SYM_SECOND = 2'd2;
	localparam logic [1:0] SYM_BOTH   = 2'd3;

	typedef struct packed {
		logic [31:0]     count;
		logic [7:0]      rate;
		logic            stopped;
		osp_pkg::phase_t phase;
	} wheel_status_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic symbol_valid = 1'b0;
	logic [1:0] sensor_symbol = SYM_NONE;
	logic result_stall = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [osp_pkg::PADDR_WIDTH-1:0] paddr = '0;
	logic [31:0] pwdata = '0;

	logic symbol_stall;
	logic result_valid;
	logic [31:0] pulse_count;
	logic [7:0] poll_rate;
	logic stopped;
	logic [3:0] phase;
	logic [31:0] prdata;
	logic pready;

	optical_sector_pulse_counter u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.symbol_valid  (symbol_valid),
		.symbol_stall  (symbol_stall),
		.sensor_symbol (sensor_symbol),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.pulse_count   (pulse_count),
		.poll_rate     (poll_rate),
		.stopped       (stopped),
		.phase         (phase),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	// register shadows
	logic [7:0] lim_dark_min  = osp_pkg::DARK_RUN_MIN_RST;
	logic [7:0] lim_run_max   = osp_pkg::RUN_LEN_MAX_RST;
	logic [7:0] lim_rate_max  = osp_pkg::RATE_MAX_RST;
	logic [7:0] lim_zero_max  = osp_pkg::ZERO_RUN_MAX_RST;
	logic [7:0] lim_init_rate = osp_pkg::INIT_RATE_RST;

	// wheel state as predicted
	osp_pkg::phase_t wheel_phase   = osp_pkg::PH_IDLE;
	logic [7:0]      wheel_zeros   = 8'd0;
	logic [7:0]      wheel_dark    = 8'd0;
	logic [7:0]      wheel_run     = 8'd0;
	logic [7:0]      wheel_rate    = osp_pkg::INIT_RATE_RST;
	logic [31:0]     wheel_count   = 32'd0;
	logic            wheel_stopped = 1'b0;

	wheel_status_t wheel_status_q [$];
	wheel_status_t want;
	logic [1:0] symbol_q [$];

	// stimulus-side tracking, keeps random traffic from stopping the wheel
	osp_pkg::phase_t gen_phase   = osp_pkg::PH_IDLE;
	int              gen_zeros   = 0;
	bit              gen_stopped = 1'b0;

	int symbols_queued = 0;
	int results_seen   = 0;
	int mismatches     = 0;
	int cycle_cnt      = 0;

	logic sym_xfer = 1'b0;
	int burst_left = 1;
	int gap_left = 0;
	int stall_mode = 0;
	int stall_span = 0;
	logic [7:0] stall_pat = 8'b1100_1000;

	function automatic osp_pkg::phase_t next_phase(input osp_pkg::phase_t cur,
	                                               input logic [1:0] sym);
		osp_pkg::phase_t nxt;
		if (cur >= osp_pkg::PH_SECTOR_B && cur <= osp_pkg::PH_ZERO_B) begin
			case (sym)
				SYM_NONE:   nxt = osp_pkg::PH_ZERO_B;
				SYM_FIRST:  nxt = osp_pkg::PH_SECTOR_A;
				SYM_SECOND: nxt = osp_pkg::PH_REPEAT_B;
				default:    nxt = osp_pkg::PH_MIXED_B;
			endcase
		end else if (cur >= osp_pkg::PH_SECTOR_A && cur <= osp_pkg::PH_ZERO_A) begin
			case (sym)
				SYM_NONE:   nxt = osp_pkg::PH_ZERO_A;
				SYM_FIRST:  nxt = osp_pkg::PH_REPEAT_A;
				SYM_SECOND: nxt = osp_pkg::PH_SECTOR_B;
				default:    nxt = osp_pkg::PH_MIXED_A;
			endcase
		end else begin
			case (sym)
				SYM_FIRST:  nxt = osp_pkg::PH_SECTOR_A;
				SYM_SECOND: nxt = osp_pkg::PH_SECTOR_B;
				default:    nxt = osp_pkg::PH_IDLE;
			endcase
		end
		return nxt;
	endfunction

	task automatic clear_wheel_runs();
		wheel_zeros = 8'd0;
		wheel_dark  = 8'd2;
		wheel_run   = 8'd1;
	endtask

	task automatic advance_wheel(input logic [1:0] sym);
		if (!wheel_stopped) begin
			wheel_phase = next_phase(wheel_phase, sym);
			case (wheel_phase)
				osp_pkg::PH_IDLE: begin
					clear_wheel_runs();
				end
				osp_pkg::PH_SECTOR_A, osp_pkg::PH_SECTOR_B: begin
					wheel_count = wheel_count + 32'd1;
					if (int'(wheel_dark) - 1 < int'(lim_dark_min) && wheel_rate != 8'd0)
						wheel_rate = wheel_rate - 8'd1;
					clear_wheel_runs();
				end
				osp_pkg::PH_REPEAT_A, osp_pkg::PH_REPEAT_B,
				osp_pkg::PH_MIXED_A, osp_pkg::PH_MIXED_B: begin
					if ((wheel_phase == osp_pkg::PH_REPEAT_A ||
					     wheel_phase == osp_pkg::PH_REPEAT_B) &&
					    wheel_dark != 8'd0)
						wheel_dark = wheel_dark + 8'd1;
					if (wheel_run < lim_run_max) begin
						wheel_run = wheel_run + 8'd1;
					end else begin
						if (wheel_rate < lim_rate_max)
							wheel_rate = wheel_rate + 8'd1;
						wheel_run = 8'd1;
					end
				end
				default: begin
					if (wheel_zeros < lim_zero_max)
						wheel_zeros = wheel_zeros + 8'd1;
					else
						wheel_stopped = 1'b1;
				end
			endcase
		end
		wheel_status_q.push_back('{wheel_count, wheel_rate, wheel_stopped, wheel_phase});
	endtask

	task automatic flag_mismatch(input string what, input longint got, input longint exp_val);
		$display("%0t mismatch %s: got %0h, want %0h", $time, what, got, exp_val);
		mismatches++;
	endtask

	task automatic queue_symbol(input logic [1:0] sym);
		if (!gen_stopped) begin
			gen_phase = next_phase(gen_phase, sym);
			if (gen_phase == osp_pkg::PH_ZERO_A || gen_phase == osp_pkg::PH_ZERO_B) begin
				if (gen_zeros < lim_zero_max)
					gen_zeros++;
				else
					gen_stopped = 1'b1;
			end else if (gen_phase == osp_pkg::PH_IDLE || gen_phase == osp_pkg::PH_SECTOR_A ||
			             gen_phase == osp_pkg::PH_SECTOR_B) begin
				gen_zeros = 0;
			end
		end
		symbol_q.push_back(sym);
		symbols_queued++;
	endtask

	// mostly rotation-like traffic: repeats, mixed, sector entries, a few dark polls
	task automatic queue_random(input int n, input bit may_stop);
		logic [1:0] sym;
		osp_pkg::phase_t nxt;
		int roll;
		bit half_b;
		repeat (n) begin
			roll = $urandom_range(0, 99);
			half_b = (gen_phase >= osp_pkg::PH_SECTOR_B);
			if (roll < 12)
				sym = SYM_NONE;
			else if (roll < 40)
				sym = SYM_BOTH;
			else if (roll < 70)
				sym = half_b ? SYM_SECOND : SYM_FIRST;
			else if (roll < 90)
				sym = half_b ? SYM_FIRST : SYM_SECOND;
			else
				sym = 2'($urandom_range(0, 3));
			nxt = next_phase(gen_phase, sym);
			if (!may_stop && (nxt == osp_pkg::PH_ZERO_A || nxt == osp_pkg::PH_ZERO_B) &&
			    gen_zeros >= int'(lim_zero_max))
				sym = SYM_BOTH;
			queue_symbol(sym);
		end
	endtask

	task automatic write_reg(input osp_pkg::reg_idx_t idx, input logic [7:0] val);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= {24'd0, val};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			osp_pkg::REG_DARK_RUN_MIN: lim_dark_min = val;
			osp_pkg::REG_RUN_LEN_MAX:  lim_run_max = val;
			osp_pkg::REG_RATE_MAX:     lim_rate_max = val;
			osp_pkg::REG_ZERO_RUN_MAX: lim_zero_max = val;
			osp_pkg::REG_INIT_RATE: begin
				lim_init_rate = val;
				wheel_rate = val;
			end
			default: ;
		endcase
	endtask

	task automatic configure(input logic [7:0] dark_min, input logic [7:0] run_max,
	                         input logic [7:0] rate_max, input logic [7:0] zero_max,
	                         input logic [7:0] init_rate);
		write_reg(osp_pkg::REG_DARK_RUN_MIN, dark_min);
		write_reg(osp_pkg::REG_RUN_LEN_MAX, run_max);
		write_reg(osp_pkg::REG_RATE_MAX, rate_max);
		write_reg(osp_pkg::REG_ZERO_RUN_MAX, zero_max);
		write_reg(osp_pkg::REG_INIT_RATE, init_rate);
	endtask

	task automatic drain();
		while (results_seen < symbols_queued)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("optical_sector_pulse_counter verification failed");
		$finish;
	end

	// symbol driver
	always @(negedge clk) begin
		if (arst_n && !(symbol_valid && !sym_xfer)) begin
			if (gap_left != 0) begin
				gap_left <= gap_left - 1;
				symbol_valid <= 1'b0;
				sensor_symbol <= 2'($urandom_range(0, 3));
			end else if (symbol_q.size() != 0) begin
				symbol_valid <= 1'b1;
				sensor_symbol <= symbol_q.pop_front();
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 24);
					gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				symbol_valid <= 1'b0;
			end
		end
	end

	// result stall pattern
	always @(negedge clk) begin
		stall_pat <= {stall_pat[0], stall_pat[7:1]};
		if (stall_span == 0) begin
			stall_mode <= $urandom_range(0, 3);
			stall_span <= $urandom_range(8, 60);
		end else begin
			stall_span <= stall_span - 1;
		end
		case (stall_mode)
			0: result_stall <= 1'b0;
			1: result_stall <= ($urandom_range(0, 2) == 0);
			2: result_stall <= stall_pat[0];
			default: result_stall <= ($urandom_range(0, 3) != 0);
		endcase
	end

	// transfer monitor
	always @(posedge clk) begin
		sym_xfer <= arst_n && symbol_valid && !symbol_stall;
		if (arst_n) begin
			if (symbol_valid && !symbol_stall)
				advance_wheel(sensor_symbol);
			if (result_valid && !result_stall) begin
				results_seen++;
				if (wheel_status_q.size() == 0) begin
					flag_mismatch("unexpected result, pulse_count", pulse_count, 0);
				end else begin
					want = wheel_status_q.pop_front();
					if (pulse_count !== want.count)
						flag_mismatch("pulse_count", pulse_count, want.count);
					if (poll_rate !== want.rate)
						flag_mismatch("poll_rate", poll_rate, want.rate);
					if (stopped !== want.stopped)
						flag_mismatch("stopped", stopped, want.stopped);
					if (phase !== want.phase)
						flag_mismatch("phase", phase, want.phase);
				end
			end
		end
	end

	initial begin
		logic [1:0] opening [$];
		opening = '{SYM_NONE, SYM_BOTH, SYM_FIRST, SYM_BOTH, SYM_FIRST, SYM_NONE, SYM_NONE,
		            SYM_SECOND, SYM_FIRST, SYM_SECOND, SYM_BOTH, SYM_BOTH, SYM_BOTH,
		            SYM_BOTH, SYM_BOTH, SYM_BOTH, SYM_BOTH, SYM_BOTH, SYM_SECOND,
		            SYM_NONE, SYM_NONE, SYM_NONE, SYM_NONE, SYM_FIRST};
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (opening[i])
			queue_symbol(opening[i]);
		// long repeat run so the dark run wraps and sticks at zero
		repeat (258) queue_symbol(SYM_FIRST);
		queue_symbol(SYM_SECOND);
		queue_random(120, 1'b0);

		drain();
		configure(8'd0, 8'd0, 8'd0, 8'd255, 8'd0);
		queue_random(180, 1'b0);

		drain();
		configure(8'd255, 8'd255, 8'd255, 8'd1, 8'd255);
		queue_random(180, 1'b0);

		repeat (3) begin
			drain();
			configure(8'($urandom_range(0, 10)), 8'($urandom_range(0, 12)),
			          8'($urandom_range(0, 15)), 8'($urandom_range(0, 6)),
			          8'($urandom_range(0, 15)));
			queue_random(150, 1'b0);
		end

		// zero limit of zero: the wheel stops and later polls are ignored
		drain();
		configure(8'($urandom_range(0, 10)), 8'($urandom_range(0, 12)),
		          8'($urandom_range(0, 15)), 8'd0, 8'($urandom_range(0, 15)));
		queue_random(40, 1'b1);
		queue_symbol(SYM_FIRST);
		queue_symbol(SYM_NONE);
		queue_random(20, 1'b1);

		drain();
		if (wheel_status_q.size() != 0)
			flag_mismatch("results missing", wheel_status_q.size(), 0);
		if (mismatches == 0) begin
			$display("optical_sector_pulse_counter verification clean");
		end else begin
			$display("optical_sector_pulse_counter verification failed");
		end
		$finish;
	end

endmodule

`default_nettype wire

// ===== files.f =====
rtl/core/osp_pkg.sv
rtl/core/optical_sector_pulse_counter.sv
sim/tb_top.sv
